// ===== src/nmed_pkg.sv =====
// ----------------------------------------------------------------------------
// nmed_pkg
// Shared constants and controller/datapath interface types for the
// neighbor-mean edge detector.
// ----------------------------------------------------------------------------
`default_nettype none

package nmed_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);       // column counter
  localparam int WCFG_W = 10;                       // image_width register
  localparam int HCFG_W = 11;                       // image_height register
  localparam int ROW_W  = HCFG_W;                   // input row may pass h
  localparam int OROW_W = $clog2(MAX_HEIGHT);       // output row counter
  localparam int PIX_W  = 8;
  localparam int SUM_W  = 11;                       // 8 * 255 fits
  localparam int FAC_W  = 12;
  localparam int SHF_W  = 4;
  localparam int PROD_W = SUM_W + FAC_W;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // reciprocal factors: x/3 = (x*2731)>>13, x/5 = (x*3277)>>14
  localparam logic [FAC_W-1:0] RECIP3 = 12'd2731;
  localparam logic [FAC_W-1:0] RECIP5 = 12'd3277;
  localparam logic [SHF_W-1:0] SHIFT3 = 4'd13;
  localparam logic [SHF_W-1:0] SHIFT5 = 4'd14;

  typedef struct packed {
    logic accept;    // latch input word, start store read
    logic step;      // shift window, write stores, advance input position
    logic sum_en;    // register masked neighbor sum
    logic mul_en;    // register reciprocal product
    logic out_load;  // load result register, advance output position
  } cmd_t;

  typedef struct packed {
    logic item_ok;   // word is acted on (not ignored)
    logic emit;      // word produces a result
    logic out_full;  // result register held by stall
  } sts_t;

endpackage

`default_nettype wire

// ===== src/nmed_ram.sv =====
// ----------------------------------------------------------------------------
// nmed_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nmed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/nmed_ctrl.sv =====
// ----------------------------------------------------------------------------
// nmed_ctrl
// Sequencer: accept, read/step, sum, multiply, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module nmed_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire nmed_pkg::sts_t sts,
  output      nmed_pkg::cmd_t cmd
);
  import nmed_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.step   = sts.item_ok;
        state_next = (sts.item_ok && sts.emit) ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/nmed_dp.sv =====
// ----------------------------------------------------------------------------
// nmed_dp
// Datapath: config registers, line buffers, 3x3 window, positions, mean and
// absolute difference, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nmed_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [nmed_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nmed_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              action,
  input  wire logic [nmed_pkg::PIX_W-1:0]        pixel,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [nmed_pkg::PIX_W-1:0]        edge_value,
  output      logic                              last_in_row,
  output      logic                              last_in_frame,
  input  wire nmed_pkg::cmd_t                    cmd,
  output      nmed_pkg::sts_t                    sts
);
  import nmed_pkg::*;

  logic [WCFG_W-1:0] image_width;
  logic [HCFG_W-1:0] image_height;
  logic [WCFG_W-1:0] w;
  logic [HCFG_W-1:0] h;

  logic [COL_W-1:0]  in_col, out_col;
  logic [ROW_W-1:0]  in_row;
  logic [OROW_W-1:0] out_row;

  logic              act;
  logic [PIX_W-1:0]  pix;
  logic [PIX_W-1:0]  win [3][3];
  logic [PIX_W-1:0]  rd_above, rd_centre;
  logic [PIX_W-1:0]  new_pix;

  logic              input_done, in_wrap;
  logic              top_ok, bot_ok, left_ok, right_ok;
  logic [SUM_W-1:0]  sum, sum_r;
  logic [1:0]        nrows, ncols;
  logic [FAC_W-1:0]  fac, fac_r;
  logic [SHF_W-1:0]  shf, shf_r, shf_m;
  logic              zero, zero_r, zero_m;
  logic [PROD_W-1:0] prod, shifted;
  logic [PIX_W-1:0]  mean, centre, diff;
  logic              row_end, frame_end, restart;

  // size clamp to 1..MAX
  always_comb begin
    if (image_width == '0) w = WCFG_W'(1);
    else if (image_width > WCFG_W'(MAX_WIDTH)) w = WCFG_W'(MAX_WIDTH);
    else w = image_width;
    if (image_height == '0) h = HCFG_W'(1);
    else if (image_height > HCFG_W'(MAX_HEIGHT)) h = HCFG_W'(MAX_HEIGHT);
    else h = image_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WCFG_W'(480);
      image_height <= HCFG_W'(640);
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH)  image_width  <= cfg_data[WCFG_W-1:0];
      if (cfg_index == REG_HEIGHT) image_height <= cfg_data;
    end
  end

  // line buffers
  nmed_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_above (
    .clk(clk), .we(cmd.step), .waddr(in_col), .wdata(rd_centre),
    .raddr(in_col), .rdata(rd_above)
  );
  nmed_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_centre (
    .clk(clk), .we(cmd.step), .waddr(in_col), .wdata(new_pix),
    .raddr(in_col), .rdata(rd_centre)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act <= action;
      pix <= pixel;
    end
  end

  assign new_pix    = (act == ACT_DRAIN) ? '0 : pix;
  assign input_done = (in_row >= h);
  assign in_wrap    = ({1'b0, in_col} + WCFG_W'(1)) >= w;

  assign sts.item_ok  = (act == ACT_DRAIN) == input_done;
  assign sts.emit     = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_col != '0);
  assign sts.out_full = out_valid && out_stall;

  // neighbor masks from output position
  assign top_ok   = (out_row != '0);
  assign bot_ok   = ({1'b0, out_row} + HCFG_W'(1)) < h;
  assign left_ok  = (out_col != '0);
  assign right_ok = ({1'b0, out_col} + WCFG_W'(1)) < w;
  assign row_end  = !right_ok;
  assign frame_end = row_end && !bot_ok;
  assign restart  = (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT))
                  || (cmd.out_load && frame_end);

  always_comb begin
    logic rok, cok;
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rok = (r == 0) ? top_ok : (r == 2) ? bot_ok : 1'b1;
        cok = (c == 0) ? left_ok : (c == 2) ? right_ok : 1'b1;
        if (rok && cok && !(r == 1 && c == 1)) begin
          sum = sum + SUM_W'(win[r][c]);
        end
      end
    end
    nrows = 2'(1) + 2'(top_ok) + 2'(bot_ok);
    ncols = 2'(1) + 2'(left_ok) + 2'(right_ok);
  end

  // divisor is nrows*ncols-1: one of 0,1,2,3,5,8
  always_comb begin
    fac  = FAC_W'(1);
    shf  = '0;
    zero = 1'b0;
    unique case ({nrows, ncols})
      {2'd1, 2'd1}: zero = 1'b1;
      {2'd1, 2'd2}, {2'd2, 2'd1}: shf = '0;
      {2'd1, 2'd3}, {2'd3, 2'd1}: shf = SHF_W'(1);
      {2'd2, 2'd2}: begin
        fac = RECIP3;
        shf = SHIFT3;
      end
      {2'd2, 2'd3}, {2'd3, 2'd2}: begin
        fac = RECIP5;
        shf = SHIFT5;
      end
      {2'd3, 2'd3}: shf = SHF_W'(3);
      default: zero = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      sum_r  <= sum;
      fac_r  <= fac;
      shf_r  <= shf;
      zero_r <= zero;
      centre <= win[1][1];
    end
    if (cmd.mul_en) begin
      prod   <= PROD_W'(sum_r) * PROD_W'(fac_r);
      shf_m  <= shf_r;
      zero_m <= zero_r;
    end
  end

  assign shifted = prod >> shf_m;
  assign mean    = shifted[PIX_W-1:0];
  assign diff    = zero_m ? '0 : (centre >= mean) ? centre - mean : mean - centre;

  // window and positions
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (cmd.step) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_above;
      win[1][2] <= rd_centre;
      win[2][2] <= new_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (cmd.step) begin
        if (in_wrap) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (cmd.out_load) begin
        if (row_end) begin
          out_col <= '0;
          out_row <= out_row + OROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      edge_value    <= diff;
      last_in_row   <= row_end;
      last_in_frame <= frame_end;
    end
  end

endmodule

`default_nettype wire

// ===== src/neighbour_mean_edge_detector.sv =====
// ----------------------------------------------------------------------------
// neighbour_mean_edge_detector
// 3x3 neighbor-mean difference edge filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, action, pixel): one word per pixel in
//   raster order (action = pixel), then image_width + 1 drain words
//   (action = drain) to flush the last row. Words that do not fit the frame
//   phase (a drain while pixels are due, a pixel while draining) are taken
//   and dropped.
//   Output channel (out_valid/out_stall, edge_value, last_in_row,
//   last_in_frame): |pixel - truncated mean of in-frame neighbors|, results
//   lag the input by one row plus one pixel.
//   Config: cfg_we/cfg_index/cfg_data, index 0 = image_width, 1 =
//   image_height. A write restarts the frame. Write only while idle.
// Timing:
//   An input word that yields no result goes through accept and line buffer
//   read + window step; one that does also goes through sum, reciprocal
//   multiply and deliver (deliver waits while stalled). The sequencer handles
//   one word at a time: a new word is taken only once the last is through.
// Reset: sync, active high; 480x640 frame, counters and window cleared.
//   Line buffers are not cleared; unwritten entries are always masked.
// Stall: a result waits in the output register; the next word is still
//   accepted and worked up to the deliver step, which waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbour_mean_edge_detector (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [nmed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nmed_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic                            action,
  input  wire logic [nmed_pkg::PIX_W-1:0]      pixel,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [nmed_pkg::PIX_W-1:0]      edge_value,
  output      logic                            last_in_row,
  output      logic                            last_in_frame
);
  import nmed_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  nmed_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  // buffers, window, arithmetic, result register
  nmed_dp u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .action(action), .pixel(pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .edge_value(edge_value), .last_in_row(last_in_row),
    .last_in_frame(last_in_frame),
    .cmd(cmd), .sts(sts)
  );

endmodule

`default_nettype wire

// ===== src/nmed_checker.sv =====
// ----------------------------------------------------------------------------
// nmed_checker
// Port-level checks for the edge detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nmed_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] edge_value,
  input wire logic       last_in_row,
  input wire logic       last_in_frame
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(edge_value) && $stable(last_in_frame))
    else $error("stalled result word changed");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_in_frame |-> last_in_row)
    else $error("frame end without row end");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken back to back");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind neighbour_mean_edge_detector nmed_checker u_nmed_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .edge_value(edge_value),
  .last_in_row(last_in_row), .last_in_frame(last_in_frame)
);

`default_nettype wire
